[rtl/core/chf_pkg.sv]
// package for the circle diagonal hatch fill core: widths, constants, codes, helpers
package chf_pkg;

  // coordinate and fraction format
  localparam int COORD_BITS    = 20;
  localparam int FRACTION_BITS = 8;

  // register field widths
  localparam int RADIUS_BITS  = 18;
  localparam int SPACING_BITS = 16;
  localparam int OFFSET_BITS  = 22;

  // shared multiplier: 18 x 18 unsigned, full product
  localparam int PROD_BITS = 2 * RADIUS_BITS;

  // 1/sqrt2 in Q.16 and its rounding half
  localparam int INV_SQRT2_Q16 = 46341;
  localparam int ROUND_HALF    = 32768;
  localparam int SCALE_SHIFT   = 16;

  // spacing reset: round(0.1 * 2^FRACTION_BITS)
  localparam int SPACING_RESET = ((1 << FRACTION_BITS) + 5) / 10;

  // coordinate sums: center plus two scaled terms of up to RADIUS_BITS+1 bits
  localparam int SUM_BITS = ((COORD_BITS > RADIUS_BITS + 1) ? COORD_BITS : RADIUS_BITS + 1) + 2;

  // configuration port widths
  localparam int CFG_ADDR_BITS = 2;
  localparam int CFG_DATA_BITS = (COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS;

  // result payload
  localparam int OUT_PAYLOAD_BITS = 4 * COORD_BITS;
  localparam int OUT_DATA_BITS    = ((OUT_PAYLOAD_BITS + 7) / 8) * 8;
  localparam int IN_DATA_BITS     = 8;

  // register indexes
  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_SPACING  = 2'd3
  } cfg_idx_t;

  // clamp a coordinate sum to the signed coordinate range
  function automatic logic [COORD_BITS-1:0] sat_coord(input logic signed [SUM_BITS-1:0] v);
    logic signed [SUM_BITS-1:0] hi;
    logic signed [SUM_BITS-1:0] lo;
    hi = SUM_BITS'((longint'(1) <<< (COORD_BITS - 1)) - 1);
    lo = -hi - SUM_BITS'(1);
    if (v > hi) begin
      sat_coord = hi[COORD_BITS-1:0];
    end else if (v < lo) begin
      sat_coord = lo[COORD_BITS-1:0];
    end else begin
      sat_coord = v[COORD_BITS-1:0];
    end
  endfunction

endpackage

[rtl/core/circle_diagonal_hatch_fill_core.sv]
// circle diagonal hatch fill core: at most one 45-degree chord per input beat
//
// channel | dir | handshake              | payload
// in_     | in  | in_tvalid / in_tready  | in_tdata[0] begin_fill
// out_    | out | out_tvalid / out_tready| out_tdata start_x..end_y, out_tlast last_chord
// cfg_    | in  | cfg_valid / cfg_ready  | cfg_addr register index, cfg_data value
//
// a beat that yields a chord holds the core from accept to next accept through these steps:
// accept, r*r, s*s, remainder, 18 root steps, three 1/sqrt2 scaling steps, output load;
// the 18-step restoring square root on the one shared multiplier datapath makes up most of it
// a beat that yields no chord (idle advance, zero radius, offset past radius) leaves the core in accept
// rst_n is synchronous, active low; it clears the fill, center and radius and sets spacing to its default
// a stalled out_ holds the chord; the core waits in the output load step until it drains
module circle_diagonal_hatch_fill_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [chf_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [0] begin_fill, rest zero
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [chf_pkg::OUT_DATA_BITS-1:0] out_tdata,  // start_x, start_y, end_x, end_y
  output logic                              out_tlast,  // last_chord
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chf_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [chf_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import chf_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RR,
    ST_SS,
    ST_REM,
    ST_SQRT,
    ST_U,
    ST_V,
    ST_VR,
    ST_OUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic signed [COORD_BITS-1:0]   center_x_r;
  logic signed [COORD_BITS-1:0]   center_y_r;
  logic [RADIUS_BITS-1:0]         radius_r;
  logic [SPACING_BITS-1:0]        spacing_r;

  // fill state
  logic signed [OFFSET_BITS-1:0]  offset_r;
  logic                           active_r;

  // datapath registers
  logic [PROD_BITS-1:0]           prod_r;
  logic [PROD_BITS-1:0]           rr_r;
  logic [PROD_BITS-1:0]           x_r;
  logic [PROD_BITS-1:0]           res_r;
  logic [PROD_BITS-1:0]           bit_r;
  logic [RADIUS_BITS-1:0]         u_mag_r;
  logic [RADIUS_BITS-1:0]         v_mag_r;

  // output register
  logic                           out_valid_r;
  logic                           out_last_r;
  logic [OUT_PAYLOAD_BITS-1:0]    out_data_r;

  // handshakes
  logic in_fire;
  logic out_load;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = OUT_DATA_BITS'(out_data_r);
  assign out_load   = (state_r == ST_OUT) && (!out_valid_r || out_tready);

  // offset bookkeeping on accept
  logic signed [OFFSET_BITS-1:0] radius_s;
  logic signed [OFFSET_BITS-1:0] s_eff;
  logic                          act_eff;
  logic                          begin_fill;

  assign begin_fill = in_tdata[0];
  assign radius_s   = $signed({{(OFFSET_BITS-RADIUS_BITS){1'b0}}, radius_r});
  assign s_eff      = begin_fill ? (OFFSET_BITS'(0) - radius_s) : offset_r;
  assign act_eff    = begin_fill ? (radius_r != '0) : active_r;

  // offset magnitude and next offset
  logic signed [OFFSET_BITS-1:0] s_abs;
  logic [RADIUS_BITS-1:0]        s_mag;
  logic                          s_neg;
  logic [SPACING_BITS-1:0]       step;
  logic signed [OFFSET_BITS-1:0] next_off;
  logic                          last_chord;

  assign s_neg      = offset_r[OFFSET_BITS-1];
  assign s_abs      = s_neg ? -offset_r : offset_r;
  assign s_mag      = s_abs[RADIUS_BITS-1:0];
  assign step       = (spacing_r == '0) ? SPACING_BITS'(1) : spacing_r;
  assign next_off   = offset_r + $signed({{(OFFSET_BITS-SPACING_BITS){1'b0}}, step});
  assign last_chord = (next_off >= radius_s);

  // shared multiplier operand select
  logic [RADIUS_BITS-1:0] mul_a;
  logic [RADIUS_BITS-1:0] mul_b;
  logic [PROD_BITS-1:0]   mul_p;

  always_comb begin
    mul_a = s_mag;
    mul_b = s_mag;
    case (state_r)
      ST_RR: begin
        mul_a = radius_r;
        mul_b = radius_r;
      end
      ST_SS: begin
        mul_a = s_mag;
        mul_b = s_mag;
      end
      ST_U: begin
        mul_a = s_mag;
        mul_b = RADIUS_BITS'(INV_SQRT2_Q16);
      end
      ST_V: begin
        mul_a = res_r[RADIUS_BITS-1:0];
        mul_b = RADIUS_BITS'(INV_SQRT2_Q16);
      end
      default: begin
        mul_a = s_mag;
        mul_b = s_mag;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round to nearest after the 1/sqrt2 product
  logic [PROD_BITS-1:0]   prod_rnd;
  logic [RADIUS_BITS-1:0] scaled;

  assign prod_rnd = prod_r + PROD_BITS'(ROUND_HALF);
  assign scaled   = prod_rnd[SCALE_SHIFT+RADIUS_BITS-1:SCALE_SHIFT];

  // restoring square root step
  logic [PROD_BITS:0]   sq_trial;
  logic                 sq_take;

  assign sq_trial = {1'b0, res_r} + {1'b0, bit_r};
  assign sq_take  = ({1'b0, x_r} >= sq_trial);

  // chord end points
  logic signed [SUM_BITS-1:0] cx_s;
  logic signed [SUM_BITS-1:0] cy_s;
  logic signed [SUM_BITS-1:0] u_s;
  logic signed [SUM_BITS-1:0] v_s;
  logic signed [SUM_BITS-1:0] sx_sum;
  logic signed [SUM_BITS-1:0] sy_sum;
  logic signed [SUM_BITS-1:0] ex_sum;
  logic signed [SUM_BITS-1:0] ey_sum;

  assign cx_s   = SUM_BITS'(center_x_r);
  assign cy_s   = SUM_BITS'(center_y_r);
  assign v_s    = $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, v_mag_r});
  assign u_s    = s_neg ? -$signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, u_mag_r})
                        :  $signed({{(SUM_BITS-RADIUS_BITS){1'b0}}, u_mag_r});
  assign sx_sum = cx_s - u_s - v_s;
  assign sy_sum = cy_s + u_s - v_s;
  assign ex_sum = cx_s - u_s + v_s;
  assign ey_sum = cy_s + u_s + v_s;

  // sequencer, datapath and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      center_x_r  <= '0;
      center_y_r  <= '0;
      radius_r    <= '0;
      spacing_r   <= SPACING_BITS'(SPACING_RESET);
      offset_r    <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_CENTER_X: center_x_r <= cfg_data[COORD_BITS-1:0];
          CFG_CENTER_Y: center_y_r <= cfg_data[COORD_BITS-1:0];
          CFG_RADIUS:   radius_r   <= cfg_data[RADIUS_BITS-1:0];
          CFG_SPACING:  spacing_r  <= cfg_data[SPACING_BITS-1:0];
          default: ;
        endcase
      end

      // output drain
      if (out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end

      prod_r <= mul_p;

      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            offset_r <= s_eff;
            active_r <= act_eff && (s_eff < radius_s);
            if (act_eff && (s_eff < radius_s)) begin
              state_r <= ST_RR;
            end
          end
        end
        ST_RR: begin
          state_r <= ST_SS;
        end
        ST_SS: begin
          rr_r    <= prod_r;
          state_r <= ST_REM;
        end
        ST_REM: begin
          x_r     <= (rr_r >= prod_r) ? (rr_r - prod_r) : '0;
          res_r   <= '0;
          bit_r   <= PROD_BITS'(1) << (PROD_BITS - 2);
          state_r <= ST_SQRT;
        end
        ST_SQRT: begin
          if (sq_take) begin
            x_r   <= x_r - sq_trial[PROD_BITS-1:0];
            res_r <= (res_r >> 1) + bit_r;
          end else begin
            res_r <= res_r >> 1;
          end
          bit_r <= bit_r >> 2;
          if (bit_r[0]) begin
            state_r <= ST_U;
          end
        end
        ST_U: begin
          state_r <= ST_V;
        end
        ST_V: begin
          u_mag_r <= scaled;
          state_r <= ST_VR;
        end
        ST_VR: begin
          v_mag_r <= scaled;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last_chord;
            out_data_r  <= {sat_coord(ey_sum), sat_coord(ex_sum),
                            sat_coord(sy_sum), sat_coord(sx_sum)};
            if (last_chord) begin
              active_r <= 1'b0;
            end else begin
              offset_r <= next_off;
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // root bit stays a single one-hot marker through the iterations
  a_sqrt_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQRT) |-> $onehot(bit_r))
    else $error("root bit marker lost");

  // half length always fits the multiplier operand
  a_len_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_U) |-> (res_r < (PROD_BITS'(1) << RADIUS_BITS)))
    else $error("half length out of range");

  // offset magnitude stays within the radius range while a chord is computed
  a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RR) |-> (s_abs < (OFFSET_BITS'(1) << RADIUS_BITS)))
    else $error("offset magnitude out of range");

  // a loaded chord returns the core to accepting and shows on the output
  a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (in_tready && out_tvalid))
    else $error("chord load did not complete");

  // a chord computation only starts from an accepted beat with a running fill
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RR) |-> ($past(in_fire) && active_r))
    else $error("chord started without accept");

endmodule

[sim/chf_chord_checker.sv]
// chord checker: watches the hatch fill core channels, predicts each chord and compares
`timescale 1ns / 1ps

module chf_chord_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  input  logic                              in_tready,
  input  logic [chf_pkg::IN_DATA_BITS-1:0]  in_tdata,   // [0] begin_fill, rest zero
  input  logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic [chf_pkg::OUT_DATA_BITS-1:0] out_tdata,  // start_x, start_y, end_x, end_y
  input  logic                              out_tlast,  // last_chord
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [chf_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [chf_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output int                                mismatches,
  output int                                chords_pending
);
  import chf_pkg::*;

  typedef struct packed {
    logic [COORD_BITS-1:0] sx;
    logic [COORD_BITS-1:0] sy;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic                  last_chord;
  } chord_t;

  // shadow registers and fill state
  logic signed [COORD_BITS-1:0]  ctr_x;
  logic signed [COORD_BITS-1:0]  ctr_y;
  logic        [RADIUS_BITS-1:0] radius;
  logic        [SPACING_BITS-1:0] spacing;
  logic signed [OFFSET_BITS-1:0] offset;
  bit                            active;

  chord_t chords_due[$];
  int     fail_count;

  // floor of the square root, one result bit per pair of input bits
  function automatic longint root_floor(input longint x);
    longint res;
    longint probe;
    res   = 0;
    probe = longint'(1) <<< 62;
    while (probe > x) probe = probe >>> 2;
    while (probe != 0) begin
      if (x >= res + probe) begin
        x   = x - (res + probe);
        res = (res >>> 1) + probe;
      end else begin
        res = res >>> 1;
      end
      probe = probe >>> 2;
    end
    return res;
  endfunction

  // multiply by 1/sqrt2 in Q.16, round half away from zero
  function automatic longint half_diag(input longint x);
    longint mag;
    longint q;
    mag = (x < 0) ? -x : x;
    q   = (mag * INV_SQRT2_Q16 + ROUND_HALF) >>> SCALE_SHIFT;
    return (x < 0) ? -q : q;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input longint v);
    longint top_v;
    longint bot_v;
    top_v = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    bot_v = -top_v - 1;
    if (v > top_v) begin
      v = top_v;
    end else if (v < bot_v) begin
      v = bot_v;
    end
    return v[COORD_BITS-1:0];
  endfunction

  // advance the fill by one beat; returns 1 when a chord comes out
  function automatic bit trace_chord(input bit restart, output chord_t c);
    longint r;
    longint s;
    longint rem;
    longint len;
    longint u;
    longint v;
    longint step;
    longint nxt;
    c = '0;
    r = radius;
    if (restart) begin
      offset = -r;
      active = (r != 0);
    end
    if (!active) return 1'b0;
    s = offset;
    // offset already past a shrunk radius
    if (s >= r) begin
      active = 1'b0;
      return 1'b0;
    end
    rem = r * r - s * s;
    if (rem < 0) rem = 0;
    len = root_floor(rem);
    u = half_diag(s);
    v = half_diag(len);
    c.sx = clamp_coord(ctr_x - u - v);
    c.sy = clamp_coord(ctr_y + u - v);
    c.ex = clamp_coord(ctr_x - u + v);
    c.ey = clamp_coord(ctr_y + u + v);
    // zero spacing steps by one
    step = (spacing != 0) ? longint'(spacing) : 1;
    nxt  = s + step;
    if (nxt >= r) begin
      c.last_chord = 1'b1;
      active       = 1'b0;
    end else begin
      c.last_chord = 1'b0;
      offset       = nxt;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    chord_t got;
    chord_t want;
    chord_t made;
    if (!rst_n) begin
      ctr_x      = '0;
      ctr_y      = '0;
      radius     = '0;
      spacing    = SPACING_BITS'(SPACING_RESET);
      offset     = '0;
      active     = 1'b0;
      fail_count = 0;
      chords_due.delete();
    end else begin
      // result beat against the oldest expected chord
      if (out_tvalid && out_tready) begin
        got.sx         = out_tdata[0*COORD_BITS +: COORD_BITS];
        got.sy         = out_tdata[1*COORD_BITS +: COORD_BITS];
        got.ex         = out_tdata[2*COORD_BITS +: COORD_BITS];
        got.ey         = out_tdata[3*COORD_BITS +: COORD_BITS];
        got.last_chord = out_tlast;
        if (chords_due.size() == 0) begin
          if (fail_count < 10) begin
            $display("%t unexpected chord: start (%0d,%0d) end (%0d,%0d) last %0b", $realtime,
                     $signed(got.sx), $signed(got.sy), $signed(got.ex), $signed(got.ey),
                     got.last_chord);
          end
          fail_count++;
        end else begin
          want = chords_due.pop_front();
          if (got != want) begin
            if (fail_count < 10) begin
              $display("%t chord mismatch: expected start (%0d,%0d) end (%0d,%0d) last %0b",
                       $realtime, $signed(want.sx), $signed(want.sy), $signed(want.ex),
                       $signed(want.ey), want.last_chord);
              $display("%t                 got      start (%0d,%0d) end (%0d,%0d) last %0b",
                       $realtime, $signed(got.sx), $signed(got.sy), $signed(got.ex),
                       $signed(got.ey), got.last_chord);
            end
            fail_count++;
          end
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_CENTER_X: ctr_x   = cfg_data[COORD_BITS-1:0];
          CFG_CENTER_Y: ctr_y   = cfg_data[COORD_BITS-1:0];
          CFG_RADIUS:   radius  = cfg_data[RADIUS_BITS-1:0];
          CFG_SPACING:  spacing = cfg_data[SPACING_BITS-1:0];
          default: ;
        endcase
      end
      // input beat
      if (in_tvalid && in_tready) begin
        if (trace_chord(in_tdata[0], made)) chords_due.push_back(made);
      end
    end
    chords_pending <= chords_due.size();
    mismatches     <= fail_count;
  end

endmodule

[sim/circle_diagonal_hatch_fill_core_tb.sv]
// testbench top: drives fills and register writes into the hatch fill core and gives the verdict
`timescale 1ns / 1ps

module circle_diagonal_hatch_fill_core_tb;
  import chf_pkg::*;

  localparam int RANDOM_BEATS  = 1600;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 3000;
  localparam int RADIUS_MAX    = (1 << RADIUS_BITS) - 1;
  localparam int MAX_FILL      = 40;

  logic                     clk;
  logic                     rst_n;
  logic                     in_tvalid;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata;   // [0] begin_fill, rest zero
  logic                     out_tvalid;
  logic                     out_tready;
  logic [OUT_DATA_BITS-1:0] out_tdata;  // start_x, start_y, end_x, end_y
  logic                     out_tlast;  // last_chord
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_ADDR_BITS-1:0] cfg_addr;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int mismatches;
  int chords_pending;
  int send_idle_pct;
  int recv_idle_pct;
  int holds_requested;
  int holds_served;
  int stall_cycles;

  circle_diagonal_hatch_fill_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  chf_chord_checker i_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tlast      (out_tlast),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_addr       (cfg_addr),
    .cfg_data       (cfg_data),
    .mismatches     (mismatches),
    .chords_pending (chords_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random back-pressure, plus a long hold when asked
  initial begin
    out_tready   = 1'b0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_requested > holds_served) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_served++;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // one input beat; valid stays high into the next beat unless the sender idles
  task automatic send_beat(input bit restart);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_BITS'(restart);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain all chords, then let a beat with no chord finish in the core
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (chords_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int      mode;
    int      fill_beats;
    int      fills;
    int      style;
    int      steps;
    int      n;
    bit      hold_due;
    longint  sp_val;
    longint  sp_eff;
    longint  r;
    longint  chords;
    logic [CFG_DATA_BITS-1:0] word;
    logic [CFG_DATA_BITS-1:0] cx;
    logic [CFG_DATA_BITS-1:0] cy;

    rst_n           = 1'b0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    cfg_valid       = 1'b0;
    cfg_addr        = CFG_CENTER_X;
    cfg_data        = '0;
    holds_requested = 0;
    send_idle_pct   = 11;
    recv_idle_pct   = 65;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // idle advance and zero radius straight after reset
    send_beat(1'b0);
    send_beat(1'b1);
    send_beat(1'b0);
    settle();

    // unit circle at the origin, half-unit spacing, one advance past the end
    write_reg(CFG_CENTER_X, '0);
    write_reg(CFG_CENTER_Y, '0);
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(256));
    write_reg(CFG_SPACING, CFG_DATA_BITS'(128));
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    settle();

    // zero spacing steps by one
    write_reg(CFG_SPACING, '0);
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(2));
    send_beat(1'b1);
    repeat (4) send_beat(1'b0);
    settle();

    // center at the field limits, largest radius and spacing: saturated ends
    write_reg(CFG_CENTER_X, 20'h7FFFF);
    write_reg(CFG_CENTER_Y, 20'h80000);
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(RADIUS_MAX));
    write_reg(CFG_SPACING, CFG_DATA_BITS'(16'hFFFF));
    send_beat(1'b1);
    repeat (2) send_beat(1'b0);
    settle();

    // opposite corner, restart over a fill left running
    write_reg(CFG_CENTER_X, 20'h80000);
    write_reg(CFG_CENTER_Y, 20'h7FFFF);
    send_beat(1'b1);
    send_beat(1'b0);
    settle();

    // radius shrunk mid-fill so the remainder goes negative
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(1000));
    write_reg(CFG_SPACING, CFG_DATA_BITS'(500));
    send_beat(1'b1);
    settle();
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(300));
    repeat (3) send_beat(1'b0);
    settle();

    // radius shrunk to the offset: the fill stops without a chord
    write_reg(CFG_RADIUS, CFG_DATA_BITS'(1000));
    send_beat(1'b1);
    send_beat(1'b0);
    settle();
    write_reg(CFG_RADIUS, '0);
    repeat (2) send_beat(1'b0);

    // random fills, three idling regimes
    mode       = 0;
    fill_beats = 0;
    hold_due   = 1'b0;
    while (fill_beats < RANDOM_BEATS) begin
      if (mode == 0 && fill_beats >= RANDOM_BEATS / 3) begin
        mode          = 1;
        send_idle_pct = 65;
        recv_idle_pct = 11;
      end else if (mode == 1 && fill_beats >= 2 * RANDOM_BEATS / 3) begin
        mode          = 2;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_due      = 1'b1;
      end
      settle();

      if (!hold_due && $urandom_range(99) < 15) begin
        // new radius under a fill that may still be running
        write_reg(CFG_RADIUS, CFG_DATA_BITS'($urandom));
        steps = $urandom_range(1, 10);
        repeat (steps) send_beat(1'b0);
        fill_beats += steps;
      end else begin
        // fresh setting
        style  = $urandom_range(99);
        sp_val = (style < 5) ? 0 : (style < 45) ? $urandom_range(1, 64) : $urandom_range(1, 65535);
        sp_eff = (sp_val == 0) ? 1 : sp_val;
        n      = hold_due ? 20 : $urandom_range(1, 24);
        style  = $urandom_range(99);
        if (!hold_due && style < 5) begin
          r = 0;
        end else if (!hold_due && style < 10) begin
          r = RADIUS_MAX;
        end else begin
          r = (sp_eff * n) / 2 + $urandom_range(0, int'(sp_eff - 1));
          if (r > RADIUS_MAX) r = RADIUS_MAX;
        end
        if ($urandom_range(99) < 10) begin
          cx = $urandom_range(1) ? 20'h7FFFF : 20'h80000;
          cy = $urandom_range(1) ? 20'h7FFFF : 20'h80000;
        end else begin
          cx = CFG_DATA_BITS'($urandom);
          cy = CFG_DATA_BITS'($urandom);
        end
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        // bits above each register's width are junk the core must drop
        word = CFG_DATA_BITS'($urandom);
        word[RADIUS_BITS-1:0] = RADIUS_BITS'(r);
        write_reg(CFG_RADIUS, word);
        word = CFG_DATA_BITS'($urandom);
        word[SPACING_BITS-1:0] = SPACING_BITS'(sp_val);
        write_reg(CFG_SPACING, word);

        // long receiver hold while the sender keeps offering
        if (hold_due) begin
          holds_requested++;
          hold_due = 1'b0;
        end

        chords = (r == 0) ? 0 : (2 * r + sp_eff - 1) / sp_eff;
        if (chords > MAX_FILL) chords = MAX_FILL;
        fills = $urandom_range(1, 3);
        repeat (fills) begin
          style = $urandom_range(99);
          if (style < 80) begin
            // fill of up to MAX_FILL chords, sometimes one advance past its end
            send_beat(1'b1);
            repeat ((chords > 0) ? chords - 1 : 0) send_beat(1'b0);
            if ($urandom_range(99) < 30) send_beat(1'b0);
            fill_beats += (chords > 0) ? int'(chords) : 1;
          end else if (style < 90) begin
            // fill cut short, restarted by the next begin
            send_beat(1'b1);
            steps = $urandom_range(0, int'(chords));
            repeat (steps) send_beat(1'b0);
            fill_beats += 1 + steps;
          end else begin
            // random begin and advance beats
            steps = $urandom_range(1, 8);
            repeat (steps) send_beat($urandom_range(1));
            fill_beats += steps;
          end
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
